// ----- hw/rtl/pobp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// OLED page block packer package
// Shared constants and types for the block transpose and link serializer.
// ----------------------------------------------------------------------------
package pobp_pkg;

    localparam int NUM_LANES       = 8;
    localparam int HEADER_BYTES    = 5;
    localparam int BYTES_PER_BLOCK = HEADER_BYTES + NUM_LANES;
    localparam int CNT_W           = $clog2(BYTES_PER_BLOCK);
    localparam int LANE_W          = $clog2(NUM_LANES);

    localparam logic [7:0] CMD_CTRL_BYTE  = 8'h00;
    localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
    localparam logic [7:0] DATA_CTRL_BYTE = 8'h40;

    localparam logic [1:0] COLUMN_OFFSET_RESET = 2'd2;

    localparam logic [CNT_W-1:0] IDX_CTRL     = CNT_W'(0);
    localparam logic [CNT_W-1:0] IDX_PAGE     = CNT_W'(1);
    localparam logic [CNT_W-1:0] IDX_COL_LOW  = CNT_W'(2);
    localparam logic [CNT_W-1:0] IDX_COL_HIGH = CNT_W'(3);
    localparam logic [CNT_W-1:0] IDX_DATA     = CNT_W'(4);
    localparam logic [CNT_W-1:0] IDX_LAST     = CNT_W'(BYTES_PER_BLOCK - 1);

    typedef logic [NUM_LANES-1:0][7:0] t_row_bytes;

    typedef struct packed {
        logic [2:0]  page;
        logic [6:0]  col;
        t_row_bytes  cols;
    } t_block;

endpackage
`default_nettype wire

// ----- hw/rtl/pobp_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transpose lane
// Gathers one pixel column of an 8x8 block into a page byte and holds it.
// ----------------------------------------------------------------------------
module pobp_lane
    import pobp_pkg::*;
#(
    parameter int LANE_IDX = 0
) (
    input  wire logic       i_clk,
    input  wire logic       i_load,
    input  wire t_row_bytes i_rows,
    output logic [7:0]      o_col
);

    logic [7:0] r_col;
    logic [7:0] n_col;

    always_comb begin
        for (int r = 0; r < NUM_LANES; r++) begin
            n_col[r] = i_rows[r][LANE_IDX];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule
`default_nettype wire

// ----- hw/rtl/pobp_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Link byte merger
// Walks the header and the lane bytes of a held block into an output register.
// ----------------------------------------------------------------------------
module pobp_merge
    import pobp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_blk_vld,
    input  wire t_block i_blk,
    output logic        o_release,
    output logic        o_tvalid,
    input  wire logic   i_tready,
    output logic [7:0]  o_tdata,
    output logic        o_tuser,
    output logic        o_tlast
);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_vld;
    logic [7:0]        r_out_byte;
    logic              r_out_eow;
    logic              r_out_last;
    logic              advance;
    logic [7:0]        n_byte;
    logic [CNT_W-1:0]  lane_off;

    assign advance  = i_blk_vld && (!r_out_vld || i_tready);
    assign lane_off = r_cnt - CNT_W'(HEADER_BYTES);

    always_comb begin
        case (r_cnt)
            IDX_CTRL:     n_byte = CMD_CTRL_BYTE;
            IDX_PAGE:     n_byte = CMD_PAGE_BASE | {5'd0, i_blk.page};
            IDX_COL_LOW:  n_byte = {4'd0, i_blk.col[3:0]};
            IDX_COL_HIGH: n_byte = CMD_COL_HIGH | {5'd0, i_blk.col[6:4]};
            IDX_DATA:     n_byte = DATA_CTRL_BYTE;
            default:      n_byte = i_blk.cols[lane_off[LANE_W-1:0]];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
            r_cnt     <= (r_cnt == IDX_LAST) ? '0 : r_cnt + CNT_W'(1);
        end else if (i_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= n_byte;
            r_out_eow  <= (r_cnt == IDX_COL_HIGH) || (r_cnt == IDX_LAST);
            r_out_last <= (r_cnt == IDX_LAST);
        end
    end

    assign o_release = advance && (r_cnt == IDX_LAST);
    assign o_tvalid  = r_out_vld;
    assign o_tdata   = r_out_byte;
    assign o_tuser   = r_out_eow;
    assign o_tlast   = r_out_last;

endmodule
`default_nettype wire

// ----- hw/rtl/oled_page_block_packer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// OLED page block packer
// Turns one 8x8 block of a row-major 1-bit framebuffer into 13 link bytes.
//
// The slave stream takes one block word: block column, page and eight row
// bytes. Eight lanes transpose the block as it is accepted and hold the
// result; the merger then emits 13 master words, one per cycle while the
// receiver is ready: a 4-byte position command (0x00, page, column low,
// column high) and 0x40 followed by the 8 page bytes. tuser flags the last
// byte of each bus write, tlast the thirteenth byte. The held block's bytes
// enter the output register in turn; a new block is accepted in the cycle
// the last byte of the held block enters it, so block throughput is set by
// the single byte-wide output. A stalled receiver holds the output word and
// the held block; at most one block waits. Reset empties the pipeline and
// sets the column offset to 2; i_cfg_wen writes it at any clock edge.
// ----------------------------------------------------------------------------
module oled_page_block_packer_top
    import pobp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic [1:0]  i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // block_col[3:0], page[6:4], row_byte_0..row_byte_7[70:7], zero[71]
    input  wire logic [71:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // link_byte[7:0]
    output logic [7:0]       o_m_axis_tdata,
    // end_of_write[0]
    output logic             o_m_axis_tuser,
    output logic             o_m_axis_tlast
);

    logic [1:0]  r_col_off;
    logic        r_blk_vld;
    logic [2:0]  r_page;
    logic [6:0]  r_col;
    logic        accept;
    logic        release_blk;
    t_row_bytes  rows;
    t_row_bytes  lane_cols;
    t_block      blk;

    assign rows            = i_s_axis_tdata[70:7];
    assign o_s_axis_tready = !r_blk_vld || release_blk;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_off <= COLUMN_OFFSET_RESET;
        end else if (i_cfg_wen) begin
            r_col_off <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_vld <= 1'b0;
        end else if (accept) begin
            r_blk_vld <= 1'b1;
        end else if (release_blk) begin
            r_blk_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= i_s_axis_tdata[6:4];
            r_col  <= {i_s_axis_tdata[3:0], 3'd0} + {5'd0, r_col_off};
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        pobp_lane #(
            .LANE_IDX (k)
        ) u_lane (
            .i_clk  (i_clk),
            .i_load (accept),
            .i_rows (rows),
            .o_col  (lane_cols[k])
        );
    end

    assign blk.page = r_page;
    assign blk.col  = r_col;
    assign blk.cols = lane_cols;

    pobp_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_blk_vld (r_blk_vld),
        .i_blk     (blk),
        .o_release (release_blk),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tuser   (o_m_axis_tuser),
        .o_tlast   (o_m_axis_tlast)
    );

endmodule
`default_nettype wire
